// ----- rtl/motor_command_string_parser_assert.svh -----
// ----------------------------------------------------------------------------
// Motor command string parser assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_STRING_PARSER_ASSERT_SVH
`define MOTOR_COMMAND_STRING_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define MCSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("motor command string parser assertion failed");

`define MCSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("motor command string parser assertion failed");

`else

`define MCSP_ASSERT_NOW(label, clk, rst, ante, cons)

`define MCSP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/mcsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor command string parser package
// Command kinds, parser codes, character constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsp_pkg;

   localparam int OUT_BITS = 32;

   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_SPEED = 3'd1;
   localparam logic [2:0] KIND_FWD   = 3'd2;
   localparam logic [2:0] KIND_REV   = 3'd3;
   localparam logic [2:0] KIND_STOP  = 3'd4;
   localparam logic [2:0] KIND_LIST  = 3'd5;
   localparam logic [2:0] KIND_LPEND = 3'd6;

   localparam logic [1:0] POS_START = 2'd0;
   localparam logic [1:0] POS_FIRST = 2'd1;
   localparam logic [1:0] POS_REST  = 2'd2;

   localparam logic [1:0] PHASE_SPACE  = 2'd0;
   localparam logic [1:0] PHASE_SIGN   = 2'd1;
   localparam logic [1:0] PHASE_DIGITS = 2'd2;
   localparam logic [1:0] PHASE_DONE   = 2'd3;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_L = 8'h4C;
   localparam logic [7:0] CHAR_UPPER_R = 8'h52;
   localparam logic [7:0] CHAR_UPPER_S = 8'h53;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic       is_zero;
      logic       is_space;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_plus;
      logic       is_minus;
      logic       is_s;
      logic [2:0] first_class;
   } char_info_type;

   typedef struct packed {
      logic [2:0]          kind;
      logic [OUT_BITS-1:0] value;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/mcsp_char_decode.sv -----
// ----------------------------------------------------------------------------
// Motor command string parser character decoder
// Classifies one command byte: terminator, white space, sign, digit, letter.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsp_char_decode (
   input  wire logic [7:0]            char_byte,
   output mcsp_pkg::char_info_type    info
);

   logic [7:0] upper;
   logic [7:0] digit_full;

   always_comb begin
      if (char_byte inside {[mcsp_pkg::CHAR_LOWER_A:mcsp_pkg::CHAR_LOWER_Z]}) begin
         upper = char_byte - mcsp_pkg::CASE_OFFSET;
      end else begin
         upper = char_byte;
      end
   end

   assign digit_full = char_byte - mcsp_pkg::CHAR_ZERO;

   always_comb begin
      info.is_zero  = (char_byte == mcsp_pkg::CHAR_NUL);
      info.is_space = (char_byte == mcsp_pkg::CHAR_SPACE) ||
                      (char_byte inside {[mcsp_pkg::CHAR_TAB:mcsp_pkg::CHAR_CR]});
      info.is_digit = char_byte inside {[mcsp_pkg::CHAR_ZERO:mcsp_pkg::CHAR_NINE]};
      info.digit    = digit_full[3:0];
      info.is_plus  = (char_byte == mcsp_pkg::CHAR_PLUS);
      info.is_minus = (char_byte == mcsp_pkg::CHAR_MINUS);
      info.is_s     = (upper == mcsp_pkg::CHAR_UPPER_S);
      case (upper)
         mcsp_pkg::CHAR_UPPER_L: info.first_class = mcsp_pkg::KIND_LPEND;
         mcsp_pkg::CHAR_UPPER_S: info.first_class = mcsp_pkg::KIND_SPEED;
         mcsp_pkg::CHAR_UPPER_F: info.first_class = mcsp_pkg::KIND_FWD;
         mcsp_pkg::CHAR_UPPER_R: info.first_class = mcsp_pkg::KIND_REV;
         mcsp_pkg::CHAR_UPPER_X: info.first_class = mcsp_pkg::KIND_STOP;
         default:                info.first_class = mcsp_pkg::KIND_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/mcsp_parse.sv -----
// ----------------------------------------------------------------------------
// Motor command string parser state
// Holds the per-string parse state and the saturating decimal accumulator,
// and forms the command result when the terminating byte is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsp_parse #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire mcsp_pkg::char_info_type info,
   output mcsp_pkg::result_type         result
);

   localparam int EXT_BITS  = VALUE_BITS + 4;
   localparam int WIDE_BITS = (VALUE_BITS > mcsp_pkg::OUT_BITS) ?
                              VALUE_BITS : mcsp_pkg::OUT_BITS;

   logic [1:0]            pos_ff,   pos_in;
   logic [2:0]            class_ff, class_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  neg_ff,   neg_in;
   logic [VALUE_BITS-1:0] mag_ff,   mag_in;
   logic                  sat_ff,   sat_in;

   logic [VALUE_BITS-1:0] half;
   logic [VALUE_BITS-1:0] limit;
   logic [EXT_BITS-1:0]   mag_ext;
   logic [EXT_BITS-1:0]   product;
   logic                  overflow;
   logic                  take_digit;
   logic [WIDE_BITS-1:0]  mag_wide;
   logic [WIDE_BITS-1:0]  mag_neg;

   assign half     = {1'b1, {(VALUE_BITS-1){1'b0}}};
   assign limit    = half - VALUE_BITS'(!neg_ff);
   assign mag_ext  = EXT_BITS'(mag_ff);
   assign product  = (mag_ext << 3) + (mag_ext << 1) + EXT_BITS'(info.digit);
   assign overflow = product > EXT_BITS'(limit);

   always_comb begin
      pos_in     = pos_ff;
      class_in   = class_ff;
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      sat_in     = sat_ff;
      take_digit = 1'b0;
      if (advance) begin
         if (info.is_zero) begin
            pos_in   = mcsp_pkg::POS_START;
            class_in = mcsp_pkg::KIND_NONE;
            phase_in = mcsp_pkg::PHASE_SPACE;
            neg_in   = 1'b0;
            mag_in   = '0;
            sat_in   = 1'b0;
         end else if (pos_ff == mcsp_pkg::POS_START) begin
            class_in = info.first_class;
            pos_in   = mcsp_pkg::POS_FIRST;
         end else begin
            pos_in = mcsp_pkg::POS_REST;
            if (pos_ff == mcsp_pkg::POS_FIRST && class_ff == mcsp_pkg::KIND_LPEND) begin
               class_in = info.is_s ? mcsp_pkg::KIND_LIST : mcsp_pkg::KIND_NONE;
            end
            if (class_ff == mcsp_pkg::KIND_SPEED) begin
               case (phase_ff)
                  mcsp_pkg::PHASE_SPACE: begin
                     if (info.is_space) begin
                        phase_in = mcsp_pkg::PHASE_SPACE;
                     end else if (info.is_plus) begin
                        phase_in = mcsp_pkg::PHASE_SIGN;
                     end else if (info.is_minus) begin
                        neg_in   = 1'b1;
                        phase_in = mcsp_pkg::PHASE_SIGN;
                     end else if (info.is_digit) begin
                        take_digit = 1'b1;
                        phase_in   = mcsp_pkg::PHASE_DIGITS;
                     end else begin
                        phase_in = mcsp_pkg::PHASE_DONE;
                     end
                  end
                  mcsp_pkg::PHASE_SIGN, mcsp_pkg::PHASE_DIGITS: begin
                     if (info.is_digit) begin
                        take_digit = 1'b1;
                        phase_in   = mcsp_pkg::PHASE_DIGITS;
                     end else begin
                        phase_in = mcsp_pkg::PHASE_DONE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
               if (take_digit && !sat_ff) begin
                  if (overflow) begin
                     mag_in = limit;
                     sat_in = 1'b1;
                  end else begin
                     mag_in = product[VALUE_BITS-1:0];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= mcsp_pkg::POS_START;
         class_ff <= mcsp_pkg::KIND_NONE;
         phase_ff <= mcsp_pkg::PHASE_SPACE;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         class_ff <= class_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
         sat_ff   <= sat_in;
      end
   end

   assign mag_wide = WIDE_BITS'(mag_ff);
   assign mag_neg  = '0 - mag_wide;

   always_comb begin
      result.kind  = mcsp_pkg::KIND_NONE;
      result.value = '0;
      if (pos_ff != mcsp_pkg::POS_START) begin
         if (class_ff == mcsp_pkg::KIND_SPEED) begin
            if (pos_ff == mcsp_pkg::POS_REST) begin
               result.kind  = mcsp_pkg::KIND_SPEED;
               result.value = neg_ff ? mag_neg[mcsp_pkg::OUT_BITS-1:0] :
                                       mag_wide[mcsp_pkg::OUT_BITS-1:0];
            end
         end else if (class_ff <= mcsp_pkg::KIND_LIST) begin
            result.kind = class_ff;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/motor_command_string_parser.sv -----
// ----------------------------------------------------------------------------
// Motor command string parser
// Parses a command string one byte per transaction; each terminating zero
// byte yields one transaction carrying the command kind and signed speed.
//
//   Channel   Ports                                         Direction  Meaning
//   req       req_valid/ready, req_char_byte                in         one command byte
//   rsp       rsp_valid/ready, rsp_command_kind/speed_value out        one parsed command
//
// One byte is accepted per cycle unless a held terminator stalls; each byte
// is applied to the parse state from the input register, and a terminator's
// result loads the output register as it is applied, which drives rsp_valid.
// Synchronous reset clears the parse state and both stage valid bits.
// While a result waits, only a terminating byte is held back; other bytes keep
// flowing until a held terminator fills the input register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_command_string_parser_assert.svh"

module motor_command_string_parser #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_command_kind,
   output logic signed [mcsp_pkg::OUT_BITS-1:0] rsp_speed_value
);

   logic                          in_vld_ff, in_vld_in;
   logic [7:0]                    in_byte_ff, in_byte_in;
   logic                          out_vld_ff, out_vld_in;
   logic [2:0]                    out_kind_ff, out_kind_in;
   logic [mcsp_pkg::OUT_BITS-1:0] out_value_ff, out_value_in;

   mcsp_pkg::char_info_type info;
   mcsp_pkg::result_type    result;
   logic                    process;
   logic                    out_load;

   mcsp_char_decode u_decode (
      .char_byte (in_byte_ff),
      .info      (info)
   );

   mcsp_parse #(
      .VALUE_BITS (VALUE_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (process),
      .info    (info),
      .result  (result)
   );

   assign process   = in_vld_ff && (!info.is_zero || !out_vld_ff || rsp_ready);
   assign out_load  = process && info.is_zero;
   assign req_ready = !in_vld_ff || process;

   always_comb begin
      in_vld_in    = req_ready ? req_valid : in_vld_ff;
      in_byte_in   = (req_valid && req_ready) ? req_char_byte : in_byte_ff;
      out_vld_in   = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_vld_ff);
      out_kind_in  = out_load ? result.kind : out_kind_ff;
      out_value_in = out_load ? result.value : out_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_command_kind = out_kind_ff;
   assign rsp_speed_value  = out_value_ff;

   `MCSP_ASSERT_NEXT(a_terminator_loads_result, clock, reset, out_load, out_vld_ff)
   `MCSP_ASSERT_NOW(a_value_only_for_speed, clock, reset, out_vld_ff && out_kind_ff != mcsp_pkg::KIND_SPEED, out_value_ff == '0)
   `MCSP_ASSERT_NOW(a_kind_in_range, clock, reset, out_vld_ff, out_kind_ff <= mcsp_pkg::KIND_LIST)

endmodule

`default_nettype wire

// ----- verif/motor_command_string_parser_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motor command string parser checker
// Watches the byte and result channels, keeps its own parse state, predicts
// the command for every accepted terminator and compares each result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module motor_command_string_parser_checker #(
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [7:0]                    req_char_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [2:0]                    rsp_command_kind,
   input  logic [mcsp_pkg::OUT_BITS-1:0] rsp_speed_value,
   output int                            error_count,
   output int                            pending_count
);

   localparam longint unsigned HALF_RANGE = 64'd1 << (VALUE_BITS - 1);

   logic [1:0]      position;
   logic [2:0]      letter_class;
   logic [1:0]      phase;
   logic            negative;
   longint unsigned magnitude;
   logic            saturated;

   mcsp_pkg::result_type expected_commands[$];
   int                   failures = 0;

   function automatic void clear_parse_state();
      position     = mcsp_pkg::POS_START;
      letter_class = mcsp_pkg::KIND_NONE;
      phase        = mcsp_pkg::PHASE_SPACE;
      negative     = 1'b0;
      magnitude    = 0;
      saturated    = 1'b0;
   endfunction

   function automatic void parse_command_char(input logic [7:0] c, output logic produced,
                                              output mcsp_pkg::result_type command);
      logic [7:0]      upper;
      logic            is_digit;
      logic            is_white;
      longint unsigned digit_value;
      longint unsigned limit;
      produced      = 1'b0;
      command.kind  = mcsp_pkg::KIND_NONE;
      command.value = '0;
      if (c == mcsp_pkg::CHAR_NUL) begin
         produced = 1'b1;
         if (position != mcsp_pkg::POS_START) begin
            if (letter_class == mcsp_pkg::KIND_SPEED) begin
               if (position == mcsp_pkg::POS_REST) begin
                  command.kind  = mcsp_pkg::KIND_SPEED;
                  command.value = negative ? mcsp_pkg::OUT_BITS'(64'd0 - magnitude)
                                           : mcsp_pkg::OUT_BITS'(magnitude);
               end
            end else if (letter_class <= mcsp_pkg::KIND_LIST) begin
               command.kind = letter_class;
            end
         end
         clear_parse_state();
      end else if (position == mcsp_pkg::POS_START) begin
         upper = (c >= mcsp_pkg::CHAR_LOWER_A && c <= mcsp_pkg::CHAR_LOWER_Z)
                 ? c - mcsp_pkg::CASE_OFFSET : c;
         case (upper)
            mcsp_pkg::CHAR_UPPER_L: letter_class = mcsp_pkg::KIND_LPEND;
            mcsp_pkg::CHAR_UPPER_S: letter_class = mcsp_pkg::KIND_SPEED;
            mcsp_pkg::CHAR_UPPER_F: letter_class = mcsp_pkg::KIND_FWD;
            mcsp_pkg::CHAR_UPPER_R: letter_class = mcsp_pkg::KIND_REV;
            mcsp_pkg::CHAR_UPPER_X: letter_class = mcsp_pkg::KIND_STOP;
            default:                letter_class = mcsp_pkg::KIND_NONE;
         endcase
         position = mcsp_pkg::POS_FIRST;
      end else begin
         if (position == mcsp_pkg::POS_FIRST && letter_class == mcsp_pkg::KIND_LPEND) begin
            letter_class = (c == mcsp_pkg::CHAR_UPPER_S ||
                            c == mcsp_pkg::CHAR_UPPER_S + mcsp_pkg::CASE_OFFSET)
                           ? mcsp_pkg::KIND_LIST : mcsp_pkg::KIND_NONE;
         end
         if (letter_class == mcsp_pkg::KIND_SPEED) begin
            is_digit = (c >= mcsp_pkg::CHAR_ZERO && c <= mcsp_pkg::CHAR_NINE);
            is_white = (c == mcsp_pkg::CHAR_SPACE) ||
                       (c >= mcsp_pkg::CHAR_TAB && c <= mcsp_pkg::CHAR_CR);
            if (phase == mcsp_pkg::PHASE_SPACE && is_white) begin
               phase = mcsp_pkg::PHASE_SPACE;
            end else if (phase == mcsp_pkg::PHASE_SPACE && c == mcsp_pkg::CHAR_PLUS) begin
               phase = mcsp_pkg::PHASE_SIGN;
            end else if (phase == mcsp_pkg::PHASE_SPACE && c == mcsp_pkg::CHAR_MINUS) begin
               negative = 1'b1;
               phase    = mcsp_pkg::PHASE_SIGN;
            end else if (phase != mcsp_pkg::PHASE_DONE && is_digit) begin
               digit_value = c - mcsp_pkg::CHAR_ZERO;
               limit       = negative ? HALF_RANGE : HALF_RANGE - 1;
               if (!saturated) begin
                  if (magnitude > (limit - digit_value) / 10) begin
                     magnitude = limit;
                     saturated = 1'b1;
                  end else begin
                     magnitude = magnitude * 10 + digit_value;
                  end
               end
               phase = mcsp_pkg::PHASE_DIGITS;
            end else begin
               phase = mcsp_pkg::PHASE_DONE;
            end
         end
         position = mcsp_pkg::POS_REST;
      end
   endfunction

   task automatic log_failure(input string what, input mcsp_pkg::result_type want,
                              input mcsp_pkg::result_type got);
      if (failures < 10) begin
         $display("%0t: %s: expected kind %0d value %0d, got kind %0d value %0d",
                  $time, what, want.kind, $signed(want.value), got.kind,
                  $signed(got.value));
      end
      failures++;
   endtask

   always @(posedge clock) begin
      logic                 produced;
      mcsp_pkg::result_type predicted;
      mcsp_pkg::result_type observed;
      mcsp_pkg::result_type oldest;
      if (reset) begin
         clear_parse_state();
         expected_commands.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed.kind  = rsp_command_kind;
            observed.value = rsp_speed_value;
            if (expected_commands.size() == 0) begin
               log_failure("unexpected result transaction", '0, observed);
            end else begin
               oldest = expected_commands.pop_front();
               if (observed.kind !== oldest.kind || observed.value !== oldest.value) begin
                  log_failure("result mismatch", oldest, observed);
               end
            end
         end
         if (req_valid && req_ready) begin
            parse_command_char(req_char_byte, produced, predicted);
            if (produced) begin
               expected_commands.push_back(predicted);
            end
         end
      end
      error_count   <= failures;
      pending_count <= expected_commands.size();
   end

endmodule

// ----- verif/tb_motor_command_string_parser.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motor command string parser testbench
// Sends directed and random command strings in bursts while the result side
// stalls on shifting patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_motor_command_string_parser;

   localparam int VALUE_BITS = 32;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_ready;
   logic [7:0]                    req_char_byte = 8'h00;
   logic                          rsp_valid;
   logic                          rsp_ready     = 1'b0;
   logic [2:0]                    rsp_command_kind;
   logic [mcsp_pkg::OUT_BITS-1:0] rsp_speed_value;
   int                            error_count;
   int                            pending_count;

   logic [7:0] command_bytes[$];
   int         stall_mode = 0;
   int         stall_left = 0;
   int         burst_left;
   int         gap;
   int         pick;
   int         count;
   string      word;
   string      directed[] = '{"", "L", "Ls", "lX", "s", "f", "R", "x", "s-7"};
   string      limits[]   = '{"2147483647", "2147483648", "2147483649", "99999999999"};

   motor_command_string_parser #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_kind (rsp_command_kind),
      .rsp_speed_value  (rsp_speed_value)
   );

   motor_command_string_parser_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_kind (rsp_command_kind),
      .rsp_speed_value  (rsp_speed_value),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= int'($urandom_range(0, 4));
         stall_left <= int'($urandom_range(8, 64));
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         3: rsp_ready <= ~rsp_ready;
         default: rsp_ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   initial begin
      foreach (directed[i]) begin
         word = directed[i];
         for (int k = 0; k < word.len(); k++) command_bytes.push_back(word[k]);
         command_bytes.push_back(mcsp_pkg::CHAR_NUL);
      end
      command_bytes.push_back(mcsp_pkg::CHAR_UPPER_S);
      command_bytes.push_back(8'hFF);
      command_bytes.push_back(mcsp_pkg::CHAR_NUL);

      while (command_bytes.size() < 1150) begin
         pick = $urandom_range(0, 9);
         if (pick <= 4) begin
            command_bytes.push_back(mcsp_pkg::CHAR_UPPER_S
                                    + ($urandom_range(0, 1) ? mcsp_pkg::CASE_OFFSET : 8'h00));
            count = $urandom_range(0, 2);
            repeat (count) begin
               gap = $urandom_range(0, 5);
               command_bytes.push_back(gap == 5 ? mcsp_pkg::CHAR_SPACE
                                                : mcsp_pkg::CHAR_TAB + 8'(gap));
            end
            gap = $urandom_range(0, 2);
            if (gap == 1) command_bytes.push_back(mcsp_pkg::CHAR_PLUS);
            if (gap == 2) command_bytes.push_back(mcsp_pkg::CHAR_MINUS);
            if ($urandom_range(0, 5) == 0) begin
               word = limits[$urandom_range(0, 3)];
               for (int k = 0; k < word.len(); k++) command_bytes.push_back(word[k]);
            end else begin
               count = $urandom_range(0, $urandom_range(0, 1) ? 14 : 6);
               repeat (count) begin
                  command_bytes.push_back(mcsp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
               end
            end
            if ($urandom_range(0, 3) == 0) begin
               count = $urandom_range(1, 3);
               repeat (count) command_bytes.push_back(8'($urandom_range(1, 255)));
            end
         end else if (pick <= 6) begin
            case ($urandom_range(0, 3))
               0: command_bytes.push_back(mcsp_pkg::CHAR_UPPER_F);
               1: command_bytes.push_back(mcsp_pkg::CHAR_UPPER_R);
               2: command_bytes.push_back(mcsp_pkg::CHAR_UPPER_X);
               default: command_bytes.push_back(mcsp_pkg::CHAR_UPPER_L);
            endcase
            if ($urandom_range(0, 1)) begin
               command_bytes[$] = command_bytes[$] + mcsp_pkg::CASE_OFFSET;
            end
            if (command_bytes[$] == mcsp_pkg::CHAR_UPPER_L ||
                command_bytes[$] == mcsp_pkg::CHAR_UPPER_L + mcsp_pkg::CASE_OFFSET) begin
               if ($urandom_range(0, 3) != 0) begin
                  command_bytes.push_back(mcsp_pkg::CHAR_UPPER_S
                                          + ($urandom_range(0, 1) ? mcsp_pkg::CASE_OFFSET
                                                                  : 8'h00));
               end else begin
                  command_bytes.push_back(8'($urandom_range(1, 255)));
               end
            end
            count = $urandom_range(0, 2);
            repeat (count) command_bytes.push_back(8'($urandom_range(1, 255)));
         end else if (pick <= 8) begin
            count = $urandom_range(0, 5);
            repeat (count) command_bytes.push_back(8'($urandom_range(1, 255)));
         end else begin
            command_bytes.push_back($urandom_range(0, 1) ? mcsp_pkg::CHAR_UPPER_S
                                                         : mcsp_pkg::CHAR_UPPER_L);
            if ($urandom_range(0, 1)) begin
               command_bytes[$] = command_bytes[$] + mcsp_pkg::CASE_OFFSET;
            end
         end
         command_bytes.push_back(mcsp_pkg::CHAR_NUL);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      burst_left = 0;
      foreach (command_bytes[i]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         req_valid     <= 1'b1;
         req_char_byte <= command_bytes[i];
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mcsp_pkg.sv
rtl/mcsp_char_decode.sv
rtl/mcsp_parse.sv
rtl/motor_command_string_parser.sv
verif/motor_command_string_parser_checker.sv
verif/tb_motor_command_string_parser.sv
